[hw/rtl/mandelbrot_escape_count_assert.svh]
// assertion macros for the escape-time counter
// each macro takes a label, clock, reset, antecedent, consequent and a message
`ifndef MANDELBROT_ESCAPE_COUNT_ASSERT_SVH
`define MANDELBROT_ESCAPE_COUNT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// consequent holds in the same cycle
`define MEC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// consequent holds in the next cycle
`define MEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define MEC_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define MEC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[hw/rtl/mec_pkg.sv]
`default_nettype none
package mec_pkg;

   // field and port widths
   localparam int COORD_W     = 8;
   localparam int COUNT_W     = 8;
   localparam int ORIGIN_W    = 24;
   localparam int STEP_W      = 16;
   localparam int LIMIT_W     = 24;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_W   = 3;

   // register indexes, byte address is 4 times the index
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_X_ORIGIN     = 3'd0,
      CSR_Y_ORIGIN     = 3'd1,
      CSR_X_STEP       = 3'd2,
      CSR_Y_STEP       = 3'd3,
      CSR_MAX_ITER     = 3'd4,
      CSR_ESCAPE_LIMIT = 3'd5
   } csr_index_type;

   // register reset values
   localparam logic signed [ORIGIN_W-1:0] X_ORIGIN_RESET     = -24'sd10240;
   localparam logic signed [ORIGIN_W-1:0] Y_ORIGIN_RESET     = -24'sd4096;
   localparam logic [STEP_W-1:0]          X_STEP_RESET       = 16'd448;
   localparam logic [STEP_W-1:0]          Y_STEP_RESET       = 16'd372;
   localparam logic [COUNT_W-1:0]         MAX_ITER_RESET     = 8'd15;
   localparam logic [LIMIT_W-1:0]         ESCAPE_LIMIT_RESET = 24'd16384;

   // input beat, column in the low bits
   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] column;
   } pixel_type;

   // result beat, out_column in the low bits
   typedef struct packed {
      logic [COUNT_W-1:0] escape_count;
      logic [COORD_W-1:0] out_row;
      logic [COORD_W-1:0] out_column;
   } result_type;

endpackage
`default_nettype wire

[hw/rtl/mandelbrot_escape_count.sv]
// Mandelbrot escape-time counter. Each req beat carries a pixel column and row; the block maps
// them to c = (column*x_step + x_origin, row*y_step + y_origin) in signed fixed point with
// FRAC_BITS fraction bits, iterates z = z*z + c from zero up to max_iter times and returns one
// rsp beat with the pixel and the exit iteration index minus one (max_iter minus one if the
// point never escapes, zero if max_iter is zero). All arithmetic wraps at DATA_WIDTH bits and
// products are shifted right arithmetically by FRAC_BITS. One set of three multipliers is
// shared by the coordinate mapping and the iteration loop: each loop pass goes through a
// multiply state (ST_MUL) and then an update state (ST_UPD). After accept a pixel passes
// through ST_COORD and ST_CADD, makes its loop passes (its iteration count, plus one more
// for the pass that detects an escape, none when max_iter is zero) and ends in ST_FINISH;
// the block takes no new pixel until it is back in ST_IDLE. The finish step waits while
// the previous result still sits unaccepted in the rsp register. req_tready is high only
// between pixels; a finished result waits in the rsp register while the next pixel is taken.
// Registers sit on an APB-style port at byte addresses 0, 4, 8, 12, 16 and 20; the user
// must write them only while no pixel is in flight, and the block itself does not enforce this.
`default_nettype none
`include "mandelbrot_escape_count_assert.svh"
module mandelbrot_escape_count
   import mec_pkg::*;
#(
   parameter int FRAC_BITS  = 12,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // pixel in
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,    // column[7:0], row[15:8]
   // result out
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,    // out_column[7:0], out_row[15:8],
                                                     // escape_count[23:16]
   // register port
   input  wire logic                   csr_psel,
   input  wire logic                   csr_penable,
   input  wire logic                   csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]       csr_prdata,
   output logic                        csr_pready
);

   localparam int DW     = DATA_WIDTH;
   localparam int CMP_W  = ((DW > LIMIT_W) ? DW : LIMIT_W) + 1;
   localparam int LANES  = 3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COORD,
      ST_CADD,
      ST_MUL,
      ST_UPD,
      ST_FINISH
   } state_type;

   // registers
   state_type                    state_ff, state_in;
   logic signed [ORIGIN_W-1:0]   x_origin_ff, x_origin_in;
   logic signed [ORIGIN_W-1:0]   y_origin_ff, y_origin_in;
   logic [STEP_W-1:0]            x_step_ff, x_step_in;
   logic [STEP_W-1:0]            y_step_ff, y_step_in;
   logic [COUNT_W-1:0]           max_iter_ff, max_iter_in;
   logic [LIMIT_W-1:0]           escape_limit_ff, escape_limit_in;
   pixel_type                    pix_ff, pix_in;
   logic signed [DW-1:0]         cre_ff, cre_in;
   logic signed [DW-1:0]         cim_ff, cim_in;
   logic signed [DW-1:0]         x_ff, x_in;
   logic signed [DW-1:0]         y_ff, y_in;
   logic signed [DW-1:0]         prod_ff [LANES];
   logic signed [DW-1:0]         prod_in [LANES];
   logic [COUNT_W-1:0]           iter_ff, iter_in;
   logic [COUNT_W-1:0]           count_ff, count_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   result_type                   rsp_data_ff, rsp_data_in;

   // combinational
   logic [DW-1:0]                mul_a [LANES];
   logic [DW-1:0]                mul_b [LANES];
   logic signed [DW-1:0]         mul_p [LANES];
   logic [DW+COORD_W-1:0]        col_shift;
   logic [DW+COORD_W-1:0]        row_shift;
   logic signed [DW-1:0]         mag;
   logic                         escape;
   logic                         req_beat;
   logic                         csr_wr;
   logic                         rsp_free;
   pixel_type                    req_pix;
   csr_index_type                csr_idx;

   assign req_pix    = pixel_type'(req_tdata);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_beat   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_data_ff);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);

   // pixel index scaled to fixed point, wrapped at the data width
   assign col_shift = (DW+COORD_W)'(pix_ff.column) << FRAC_BITS;
   assign row_shift = (DW+COORD_W)'(pix_ff.row) << FRAC_BITS;

   // shared multiplier lanes: coordinate scaling, then x*x, y*y, x*y
   always_comb begin
      mul_a[0] = x_ff;
      mul_b[0] = x_ff;
      mul_a[1] = y_ff;
      mul_b[1] = y_ff;
      mul_a[2] = x_ff;
      mul_b[2] = y_ff;
      if (state_ff == ST_COORD) begin
         mul_a[0] = col_shift[DW-1:0];
         mul_b[0] = DW'(x_step_ff);
         mul_a[1] = row_shift[DW-1:0];
         mul_b[1] = DW'(y_step_ff);
      end
      for (int k = 0; k < LANES; k++) begin
         mul_p[k]   = DW'(mul_a[k] * mul_b[k]);
         prod_in[k] = mul_p[k] >>> FRAC_BITS;
      end
   end

   // escape test on the wrapped signed magnitude
   assign mag    = prod_ff[0] + prod_ff[1];
   assign escape = CMP_W'(mag) > $signed(CMP_W'(escape_limit_ff));

   // register read
   always_comb begin
      case (csr_idx)
         CSR_X_ORIGIN:     csr_prdata = CSR_DATA_W'(x_origin_ff);
         CSR_Y_ORIGIN:     csr_prdata = CSR_DATA_W'(y_origin_ff);
         CSR_X_STEP:       csr_prdata = CSR_DATA_W'(x_step_ff);
         CSR_Y_STEP:       csr_prdata = CSR_DATA_W'(y_step_ff);
         CSR_MAX_ITER:     csr_prdata = CSR_DATA_W'(max_iter_ff);
         CSR_ESCAPE_LIMIT: csr_prdata = CSR_DATA_W'(escape_limit_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // register write
   always_comb begin
      x_origin_in     = x_origin_ff;
      y_origin_in     = y_origin_ff;
      x_step_in       = x_step_ff;
      y_step_in       = y_step_ff;
      max_iter_in     = max_iter_ff;
      escape_limit_in = escape_limit_ff;
      if (csr_wr) begin
         case (csr_idx)
            CSR_X_ORIGIN:     x_origin_in     = csr_pwdata[ORIGIN_W-1:0];
            CSR_Y_ORIGIN:     y_origin_in     = csr_pwdata[ORIGIN_W-1:0];
            CSR_X_STEP:       x_step_in       = csr_pwdata[STEP_W-1:0];
            CSR_Y_STEP:       y_step_in       = csr_pwdata[STEP_W-1:0];
            CSR_MAX_ITER:     max_iter_in     = csr_pwdata[COUNT_W-1:0];
            CSR_ESCAPE_LIMIT: escape_limit_in = csr_pwdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pix_in       = pix_ff;
      cre_in       = cre_ff;
      cim_in       = cim_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      iter_in      = iter_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_beat) begin
               pix_in   = req_pix;
               state_in = ST_COORD;
            end
         end
         ST_COORD: begin
            state_in = ST_CADD;
         end
         // c from the scaled index plus origin, z starts at zero
         ST_CADD: begin
            cre_in   = prod_ff[0] + DW'(x_origin_ff);
            cim_in   = prod_ff[1] + DW'(y_origin_ff);
            x_in     = '0;
            y_in     = '0;
            iter_in  = '0;
            count_in = '0;
            state_in = (max_iter_ff == '0) ? ST_FINISH : ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_UPD;
         end
         // escape check, else z = z*z + c
         ST_UPD: begin
            if (escape) begin
               count_in = (iter_ff == '0) ? '0 : iter_ff - 1'b1;
               state_in = ST_FINISH;
            end else begin
               x_in    = prod_ff[0] - prod_ff[1] + cre_ff;
               y_in    = (prod_ff[2] <<< 1) + cim_ff;
               iter_in = iter_ff + 1'b1;
               if (iter_ff + 1'b1 == max_iter_ff) begin
                  count_in = max_iter_ff - 1'b1;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         // hand over to the result register once it is free
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.out_column   = pix_ff.column;
               rsp_data_in.out_row      = pix_ff.row;
               rsp_data_in.escape_count = count_ff;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         x_origin_ff     <= X_ORIGIN_RESET;
         y_origin_ff     <= Y_ORIGIN_RESET;
         x_step_ff       <= X_STEP_RESET;
         y_step_ff       <= Y_STEP_RESET;
         max_iter_ff     <= MAX_ITER_RESET;
         escape_limit_ff <= ESCAPE_LIMIT_RESET;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         x_origin_ff     <= x_origin_in;
         y_origin_ff     <= y_origin_in;
         x_step_ff       <= x_step_in;
         y_step_ff       <= y_step_in;
         max_iter_ff     <= max_iter_in;
         escape_limit_ff <= escape_limit_in;
      end
      pix_ff      <= pix_in;
      cre_ff      <= cre_in;
      cim_ff      <= cim_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      iter_ff     <= iter_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
      for (int k = 0; k < LANES; k++) begin
         prod_ff[k] <= prod_in[k];
      end
   end

   // checks
   `MEC_ASSERT_NEXT(a_accept_starts_coord, clock, reset, req_beat, state_ff == ST_COORD, "pixel accepted without starting coordinate mapping")
   `MEC_ASSERT_SAME(a_result_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH, "result raised outside the finish step")
   `MEC_ASSERT_NEXT(a_finish_fills_slot, clock, reset, (state_ff == ST_FINISH) && !rsp_valid_ff, rsp_valid_ff && (state_ff == ST_IDLE), "free result register not filled on finish")

endmodule
`default_nettype wire

[verif/mandelbrot_escape_count_tb.sv]
`timescale 1ns / 100ps

module mandelbrot_escape_count_tb;
   import mec_pkg::*;

   localparam int Q_FRAC          = 12;
   localparam int MAX_BUSY_CYCLES = 2 * 255 + 4;
   localparam int CYCLE_LIMIT     = 3_000_000;
   localparam int PHASES          = 16;
   localparam int PHASE_PIXELS    = 80;
   localparam int DEEP_PHASE      = 5;
   localparam int DEEP_PIXELS     = 40;
   localparam int PAUSE_PHASE     = 2;

   // register indexes past the end of the map, writes there must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef logic signed [31:0] word_type;

   typedef enum bit {STEP_WRITE, STEP_PIXEL} plan_kind_type;

   typedef struct {
      plan_kind_type        kind;
      logic [CSR_IDX_W-1:0] index;
      logic [31:0]          value;
      logic [COORD_W-1:0]   column;
      logic [COORD_W-1:0]   row;
      bit                   typed;
      logic [COUNT_W-1:0]   count;
   } plan_step_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_psel = 1'b0;
   logic                   csr_penable = 1'b0;
   logic                   csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_paddr = '0;
   logic [CSR_DATA_W-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_W-1:0]  csr_prdata;
   logic                   csr_pready;

   // register shadow used by the escape predictor
   logic signed [ORIGIN_W-1:0] cfg_x_origin     = X_ORIGIN_RESET;
   logic signed [ORIGIN_W-1:0] cfg_y_origin     = Y_ORIGIN_RESET;
   logic [STEP_W-1:0]          cfg_x_step       = X_STEP_RESET;
   logic [STEP_W-1:0]          cfg_y_step       = Y_STEP_RESET;
   logic [COUNT_W-1:0]         cfg_max_iter     = MAX_ITER_RESET;
   logic [LIMIT_W-1:0]         cfg_escape_limit = ESCAPE_LIMIT_RESET;

   result_type    predicted_escapes[$];
   plan_step_type plan[$];
   int            sender_idle_pct    = 0;
   int            receiver_stall_pct = 0;
   int            error_count        = 0;
   int            escapes_checked    = 0;
   int            pixels_sent        = 0;
   int            cycle_count        = 0;

   mandelbrot_escape_count i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),    // column[7:0], row[15:8]
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),    // out_column[7:0], out_row[15:8], escape_count[23:16]
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Q12 product, wrapped to 32 bits, then floor shift
   function automatic word_type fx_mul(input word_type a, input word_type b);
      logic signed [63:0] wide;
      word_type           low;
      wide = a * b;
      low = wide[31:0];
      return low >>> Q_FRAC;
   endfunction

   // escape-time count of one pixel under the current register shadow
   function automatic result_type escape_time(input pixel_type px);
      word_type   c_re, c_im, x, y, x2, y2, mag, x_next;
      int         iter;
      bit         escaped;
      result_type res;
      c_re = fx_mul({12'd0, px.column, 12'd0}, {16'd0, cfg_x_step})
             + {{8{cfg_x_origin[ORIGIN_W-1]}}, cfg_x_origin};
      c_im = fx_mul({12'd0, px.row, 12'd0}, {16'd0, cfg_y_step})
             + {{8{cfg_y_origin[ORIGIN_W-1]}}, cfg_y_origin};
      x = '0;
      y = '0;
      iter = 0;
      escaped = 1'b0;
      while (iter < cfg_max_iter && !escaped) begin
         x2 = fx_mul(x, x);
         y2 = fx_mul(y, y);
         mag = x2 + y2;
         // signed compare, a wrapped negative magnitude stays inside
         if (mag > $signed({8'd0, cfg_escape_limit})) begin
            escaped = 1'b1;
         end else begin
            x_next = x2 - y2 + c_re;
            y = (fx_mul(x, y) <<< 1) + c_im;
            x = x_next;
            iter++;
         end
      end
      res.out_column = px.column;
      res.out_row = px.row;
      res.escape_count = (iter == 0) ? 8'd0 : 8'(iter - 1);
      return res;
   endfunction

   task automatic add_write(input logic [CSR_IDX_W-1:0] index, input logic [31:0] value);
      plan_step_type s;
      s.kind = STEP_WRITE;
      s.index = index;
      s.value = value;
      s.column = '0;
      s.row = '0;
      s.typed = 1'b0;
      s.count = '0;
      plan.push_back(s);
   endtask

   task automatic add_pixel(input logic [7:0] column, input logic [7:0] row, input bit typed,
                            input logic [7:0] count);
      plan_step_type s;
      s.kind = STEP_PIXEL;
      s.index = '0;
      s.value = '0;
      s.column = column;
      s.row = row;
      s.typed = typed;
      s.count = count;
      plan.push_back(s);
   endtask

   // apb write: setup and access phases, then the bus returns to idle
   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (index)
         CSR_X_ORIGIN:     cfg_x_origin = value[ORIGIN_W-1:0];
         CSR_Y_ORIGIN:     cfg_y_origin = value[ORIGIN_W-1:0];
         CSR_X_STEP:       cfg_x_step = value[STEP_W-1:0];
         CSR_Y_STEP:       cfg_y_step = value[STEP_W-1:0];
         CSR_MAX_ITER:     cfg_max_iter = value[COUNT_W-1:0];
         CSR_ESCAPE_LIMIT: cfg_escape_limit = value[LIMIT_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // drop valid and hold off until every pixel has come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (predicted_escapes.size() != 0);
   endtask

   // present one pixel beat after a random gap, valid stays up after accept
   task automatic send_pixel(input pixel_type px, input result_type outcome);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      do @(posedge clock); while (!req_tready);
      predicted_escapes.push_back(outcome);
      pixels_sent++;
   endtask

   task automatic set_idle_mode(input int mode);
      case (mode)
         0: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 0;
         end
         1: begin
            sender_idle_pct = 69;
            receiver_stall_pct = 0;
         end
         2: begin
            sender_idle_pct = 0;
            receiver_stall_pct = 69;
         end
         default: begin
            sender_idle_pct = 34;
            receiver_stall_pct = 34;
         end
      endcase
   endtask

   // result side: random stalls and the scoreboard check
   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (predicted_escapes.size() == 0) begin
               $error("result beat with no pixel pending, tdata %h", rsp_tdata);
               error_count++;
            end else begin
               want = predicted_escapes.pop_front();
               escapes_checked++;
               if (got.out_column !== want.out_column) begin
                  $error("out_column expected %0d actual %0d", want.out_column, got.out_column);
                  error_count++;
               end
               if (got.out_row !== want.out_row) begin
                  $error("out_row expected %0d actual %0d", want.out_row, got.out_row);
                  error_count++;
               end
               if (got.escape_count !== want.escape_count) begin
                  $error("escape_count expected %0d actual %0d (pixel %0d,%0d)",
                         want.escape_count, got.escape_count, want.out_column, want.out_row);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      pixel_type  px;
      result_type outcome;
      int         xo, yo, xs, ys, mi, lim, n_pixels;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset window: corner escapes after the first iteration, far corner and an interior point
      add_pixel(8'd0, 8'd0, 1'b1, 8'd0);
      add_pixel(8'd255, 8'd255, 1'b0, 8'd0);
      add_pixel(8'd23, 8'd11, 1'b0, 8'd0);
      // writes past the register map are dropped
      add_write(CSR_SPARE_A, 32'hFFFF_FFFF);
      add_write(CSR_SPARE_B, 32'h1234_5678);
      add_pixel(8'd0, 8'd0, 1'b1, 8'd0);
      add_pixel(8'd128, 8'd64, 1'b0, 8'd0);
      // c at the origin never escapes a zero limit, full iteration count
      add_write(CSR_X_ORIGIN, 32'd0);
      add_write(CSR_Y_ORIGIN, 32'd0);
      add_write(CSR_X_STEP, 32'd0);
      add_write(CSR_Y_STEP, 32'd0);
      add_write(CSR_MAX_ITER, 32'd255);
      add_write(CSR_ESCAPE_LIMIT, 32'd0);
      add_pixel(8'd255, 8'd255, 1'b1, 8'd254);
      add_pixel(8'd0, 8'd0, 1'b1, 8'd254);
      // one iteration, then none at all
      add_write(CSR_MAX_ITER, 32'd1);
      add_pixel(8'd170, 8'd85, 1'b1, 8'd0);
      add_write(CSR_MAX_ITER, 32'd0);
      add_pixel(8'd85, 8'd170, 1'b1, 8'd0);
      // c = 1.0: magnitude equal to the limit keeps going, one above escapes
      add_write(CSR_X_ORIGIN, 32'd4096);
      add_write(CSR_MAX_ITER, 32'd10);
      add_write(CSR_ESCAPE_LIMIT, 32'd4096);
      add_pixel(8'd7, 8'd9, 1'b1, 8'd1);
      add_write(CSR_ESCAPE_LIMIT, 32'd4095);
      add_pixel(8'd7, 8'd9, 1'b1, 8'd0);
      // register extremes, heavy wrapping in the mapping and the loop
      add_write(CSR_X_ORIGIN, 32'd8388607);
      add_write(CSR_Y_ORIGIN, -32'sd8388608);
      add_write(CSR_X_STEP, 32'd65535);
      add_write(CSR_Y_STEP, 32'd65535);
      add_write(CSR_MAX_ITER, 32'd255);
      add_write(CSR_ESCAPE_LIMIT, 32'd16777215);
      add_pixel(8'd0, 8'd0, 1'b0, 8'd0);
      add_pixel(8'd255, 8'd255, 1'b0, 8'd0);
      add_pixel(8'd255, 8'd0, 1'b0, 8'd0);
      add_pixel(8'd0, 8'd255, 1'b0, 8'd0);
      add_write(CSR_X_ORIGIN, -32'sd8388608);
      add_write(CSR_Y_ORIGIN, 32'd8388607);
      add_write(CSR_X_STEP, 32'd0);
      add_write(CSR_ESCAPE_LIMIT, 32'd0);
      add_pixel(8'd0, 8'd0, 1'b0, 8'd0);
      add_pixel(8'd128, 8'd128, 1'b0, 8'd0);
      // back to the reset window
      add_write(CSR_X_ORIGIN, X_ORIGIN_RESET);
      add_write(CSR_Y_ORIGIN, Y_ORIGIN_RESET);
      add_write(CSR_X_STEP, X_STEP_RESET);
      add_write(CSR_Y_STEP, Y_STEP_RESET);
      add_write(CSR_MAX_ITER, MAX_ITER_RESET);
      add_write(CSR_ESCAPE_LIMIT, ESCAPE_LIMIT_RESET);
      add_pixel(8'd16, 8'd16, 1'b0, 8'd0);
      add_pixel(8'd31, 8'd21, 1'b0, 8'd0);

      // directed walk, no idling
      set_idle_mode(0);
      foreach (plan[k]) begin
         if (plan[k].kind == STEP_WRITE) begin
            wait_for_results();
            write_csr(plan[k].index, plan[k].value);
         end else begin
            px.column = plan[k].column;
            px.row = plan[k].row;
            outcome = escape_time(px);
            if (plan[k].typed)
               outcome.escape_count = plan[k].count;
            send_pixel(px, outcome);
         end
      end

      // random windows, one register setting and one idle pattern per phase
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_results();
         if (phase == DEEP_PHASE || $urandom_range(9) < 7) begin
            // view around the set with realistic steps
            xo = int'($urandom_range(14336)) - 10240;
            yo = int'($urandom_range(12288)) - 8192;
            xs = $urandom_range(64, 4);
            ys = $urandom_range(64, 4);
            lim = ($urandom_range(3) == 0) ? $urandom_range(65535) : 16384;
            mi = (phase == DEEP_PHASE) ? 255 : $urandom_range(48, 1);
         end else begin
            // anything the registers hold
            xo = int'($urandom_range(16777215)) - 8388608;
            yo = int'($urandom_range(16777215)) - 8388608;
            xs = $urandom_range(65535);
            ys = $urandom_range(65535);
            lim = $urandom_range(16777215);
            mi = $urandom_range(255, 1);
         end
         write_csr(CSR_X_ORIGIN, xo);
         write_csr(CSR_Y_ORIGIN, yo);
         write_csr(CSR_X_STEP, xs);
         write_csr(CSR_Y_STEP, ys);
         write_csr(CSR_MAX_ITER, mi);
         write_csr(CSR_ESCAPE_LIMIT, lim);
         set_idle_mode(phase % 4);
         n_pixels = (phase == DEEP_PHASE) ? DEEP_PIXELS : PHASE_PIXELS;
         for (int n = 0; n < n_pixels; n++) begin
            if (phase == PAUSE_PHASE && n == n_pixels / 2)
               wait_for_results();
            px.column = $urandom_range(255);
            px.row = $urandom_range(255);
            send_pixel(px, escape_time(px));
         end
      end

      wait_for_results();
      repeat (MAX_BUSY_CYCLES + 50) @(posedge clock);
      $display("checked %0d escape counts from %0d pixels: directed corners and limits,",
               escapes_checked, pixels_sent);
      $display("then %0d random register settings under four idle patterns", PHASES);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
